FILE: sv/nsfc_pkg.sv
// Shared types, constants and helpers of the NMEA sentence framer and checker.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package nsfc_pkg;

	// Longest sentence before framing restarts
	localparam int MAX_LEN = 256;
	localparam int POS_W   = $clog2(MAX_LEN);

	// Result field widths and a common width for extending offsets
	localparam int LEN_W = 9;
	localparam int OFF_W = 8;
	localparam int EXT_W = (POS_W + 1 > LEN_W) ? POS_W + 1 : LEN_W;

	// Queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef logic [POS_W-1:0] pos_t;

	localparam pos_t POS_LAST = pos_t'(MAX_LEN - 1);
	localparam logic [LEN_W-1:0] OVER_LEN = LEN_W'(MAX_LEN % (1 << LEN_W));

	// Byte classes found by the front end
	typedef enum logic [2:0] {
		CLS_OTHER = 3'd0,
		CLS_START = 3'd1,
		CLS_COMMA = 3'd2,
		CLS_STAR  = 3'd3,
		CLS_CR    = 3'd4
	} cls_t;

	typedef enum logic [2:0] {
		V_ACCEPT     = 3'd0,
		V_TOLERATED  = 3'd1,
		V_MALFORMED  = 3'd2,
		V_REJECTED   = 3'd3,
		V_OVERLENGTH = 3'd4
	} verdict_t;

	// One classified byte
	typedef struct packed {
		logic [7:0] data;
		cls_t       cls;
		logic       is_lf;
		logic       nonprint;
		logic [3:0] hex;
	} item_t;

	// One sentence verdict with its report fields
	typedef struct packed {
		verdict_t         verdict;
		logic [LEN_W-1:0] length;
		logic [OFF_W-1:0] comma_off;
		logic [OFF_W-1:0] body_end;
		logic             has_sum;
		logic [7:0]       computed;
		logic [7:0]       received;
		logic             nonprint;
	} result_t;

	// Mask an offset to the report width
	function automatic logic [OFF_W-1:0] off_mask(pos_t p);
		logic [EXT_W-1:0] w;
		w = EXT_W'(p);
		return w[OFF_W-1:0];
	endfunction

	// Sentence length from the CR offset: CR and the byte after it included
	function automatic logic [LEN_W-1:0] len_of(pos_t cr_off);
		logic [EXT_W-1:0] w;
		w = EXT_W'(cr_off) + EXT_W'(2);
		return w[LEN_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: sv/nsfc_front.sv
// Front end: accepts received bytes and classifies them for the back end.
// Depends on nsfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nsfc_front (
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [7:0]    data_byte,
	input  wire logic          q_full,
	output logic               push,
	output nsfc_pkg::item_t    item
);
	import nsfc_pkg::*;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TILDE  = 8'h7E;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	// Hex digit value; anything else reads zero
	function automatic logic [3:0] hex_nibble(logic [7:0] b);
		if (b >= 8'h30 && b <= 8'h39) begin
			return 4'(b - 8'h30);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			return 4'(b - 8'h37);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			return 4'(b - 8'h57);
		end
		return 4'h0;
	endfunction

	// Hold the sender off while the queue is full
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// Classify the byte
	always_comb begin
		item.data     = data_byte;
		item.is_lf    = (data_byte == CH_LF);
		item.hex      = hex_nibble(data_byte);
		item.nonprint = 1'b0;
		unique case (data_byte)
			CH_DOLLAR, CH_BANG: item.cls = CLS_START;
			CH_COMMA:           item.cls = CLS_COMMA;
			CH_STAR:            item.cls = CLS_STAR;
			CH_CR:              item.cls = CLS_CR;
			default: begin
				item.cls      = CLS_OTHER;
				item.nonprint = (data_byte <= CH_SPACE) || (data_byte > CH_TILDE);
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: sv/nsfc_queue.sv
// Short queue of classified bytes between the front and back ends.
// Depends on nsfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nsfc_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire nsfc_pkg::item_t  push_item,
	output logic                  full,
	input  wire logic             pop,
	output logic                  head_valid,
	output nsfc_pkg::item_t       head
);
	import nsfc_pkg::*;

	item_t             entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];

	// Store an entry at the write pointer
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and track the fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: sv/nsfc_back.sv
// Back end: frames sentences from classified bytes, checks them and holds the result.
// Depends on nsfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nsfc_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             tolerate,
	input  wire logic             head_valid,
	input  wire nsfc_pkg::item_t  head,
	output logic                  pop,
	output logic                  res_valid,
	input  wire logic             res_stall,
	output nsfc_pkg::result_t     res
);
	import nsfc_pkg::*;

	typedef struct packed {
		pos_t       pos;
		logic [7:0] xsum;
		logic       star;
		pos_t       star_off;
		pos_t       comma_off;
		logic       start_ok;
		logic       cr;
		pos_t       cr_off;
		logic [3:0] hex_hi;
		logic [3:0] hex_lo;
		logic       nonprint;
	} frame_t;

	frame_t     fr_q;
	frame_t     fr_nxt;
	logic       res_valid_q;
	result_t    res_q;
	result_t    res_nxt;
	logic       emit;
	logic       star_ok;
	logic [7:0] recv;

	// Take the next byte whenever the result register is free or draining
	assign pop       = head_valid && (!res_valid_q || !res_stall);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Checksum field placement and received value
	assign star_ok = !fr_q.star ||
		((fr_q.cr_off >= pos_t'(3)) && (fr_q.star_off == fr_q.cr_off - pos_t'(3)));
	assign recv    = (fr_q.star && star_ok) ? {fr_q.hex_hi, fr_q.hex_lo} : 8'h00;

	// Update the frame for one byte and build its result
	always_comb begin
		fr_nxt  = fr_q;
		res_nxt = '0;
		emit    = 1'b0;
		if (fr_q.cr) begin
			// byte after CR ends the sentence
			emit = 1'b1;
			priority if (!fr_q.start_ok || !head.is_lf || !star_ok) begin
				res_nxt.verdict = V_MALFORMED;
			end else if (fr_q.star && (recv != fr_q.xsum)) begin
				res_nxt.verdict = tolerate ? V_TOLERATED : V_REJECTED;
			end else begin
				res_nxt.verdict = V_ACCEPT;
			end
			res_nxt.length    = len_of(fr_q.cr_off);
			res_nxt.comma_off = off_mask(fr_q.comma_off);
			res_nxt.body_end  = off_mask(fr_q.star ? fr_q.star_off : fr_q.cr_off);
			res_nxt.has_sum   = fr_q.star;
			res_nxt.computed  = fr_q.xsum;
			res_nxt.received  = recv;
			res_nxt.nonprint  = fr_q.nonprint;
			fr_nxt            = '0;
		end else begin
			unique case (head.cls)
				CLS_START: fr_nxt.start_ok = (fr_q.pos == '0);
				CLS_COMMA: begin
					if (fr_q.comma_off == '0) begin
						fr_nxt.comma_off = fr_q.pos;
					end
				end
				CLS_STAR: begin
					fr_nxt.star     = 1'b1;
					fr_nxt.star_off = fr_q.pos;
				end
				CLS_CR: begin
					fr_nxt.cr     = 1'b1;
					fr_nxt.cr_off = fr_q.pos;
				end
				CLS_OTHER: begin
					if (head.nonprint) begin
						fr_nxt.nonprint = 1'b1;
					end
				end
				default: fr_nxt = fr_q;
			endcase
			// accumulate checksum and keep the last two hex digits before CR
			if (head.cls != CLS_CR) begin
				if ((fr_q.pos != '0) && !fr_nxt.star) begin
					fr_nxt.xsum = fr_q.xsum ^ head.data;
				end
				fr_nxt.hex_hi = fr_q.hex_lo;
				fr_nxt.hex_lo = head.hex;
			end
			fr_nxt.pos = fr_q.pos + pos_t'(1);
			// drop a sentence that fills the maximum length
			if (fr_q.pos == POS_LAST) begin
				emit           = 1'b1;
				res_nxt        = '0;
				res_nxt.verdict = V_OVERLENGTH;
				res_nxt.length = OVER_LEN;
				fr_nxt         = '0;
			end
		end
	end

	// Frame state and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fr_q        <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				fr_q <= fr_nxt;
			end
			if (!res_valid_q || !res_stall) begin
				res_valid_q <= pop && emit;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			res_q <= res_nxt;
		end
	end

endmodule

`default_nettype wire

FILE: sv/nmea_sentence_framer_checker.sv
// Top level of the NMEA sentence framer and checksum checker.
// Depends on nsfc_pkg, nsfc_front, nsfc_queue and nsfc_back.
`timescale 1ns / 1ps
`default_nettype none

// Takes one received byte per cycle while in_stall is low and gives one
// verdict per sentence, once the byte that follows the CR has been taken,
// or when a sentence fills MAX_LEN bytes without ending. Each accepted byte
// waits in the queue until the back end pops it; popping the byte that ends
// a sentence registers its verdict in the result register behind out_valid.
// The front end classifies each byte and writes it into a two-entry queue;
// the back end updates the framing state with one byte per cycle, so the
// sustained rate is one byte per clock while out_stall stays low. in_stall
// rises only when the queue is full, which can happen while downstream holds
// out_stall against a waiting result; after out_stall drops, in_stall falls
// once the queue has popped an entry, since full comes from its fill count.
// tolerate_q is written through cfg_valid/cfg_data (cfg_ready is
// always high) and should be changed only while no sentence is in flight.
module nmea_sentence_framer_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic                          cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [7:0]                    data_byte,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [2:0]                         verdict,
	output logic [nsfc_pkg::LEN_W-1:0]         sentence_length,
	output logic [nsfc_pkg::OFF_W-1:0]         comma_offset,
	output logic [nsfc_pkg::OFF_W-1:0]         body_end_offset,
	output logic                               has_checksum,
	output logic [7:0]                         computed_sum,
	output logic [7:0]                         received_sum,
	output logic                               nonprintable_seen
);
	import nsfc_pkg::*;

	logic    tolerate_q;
	logic    q_full;
	logic    push;
	item_t   push_item;
	logic    pop;
	logic    head_valid;
	item_t   head;
	result_t res;

	// Configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerate_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			tolerate_q <= cfg_data;
		end
	end

	nsfc_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.q_full    (q_full),
		.push      (push),
		.item      (push_item)
	);

	nsfc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	nsfc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.tolerate   (tolerate_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.res_valid  (out_valid),
		.res_stall  (out_stall),
		.res        (res)
	);

	// Unpack the result
	assign verdict           = res.verdict;
	assign sentence_length   = res.length;
	assign comma_offset      = res.comma_off;
	assign body_end_offset   = res.body_end;
	assign has_checksum      = res.has_sum;
	assign computed_sum      = res.computed;
	assign received_sum      = res.received;
	assign nonprintable_seen = res.nonprint;

endmodule

`default_nettype wire
